[rtl/bfiq_pkg.sv]
// ----------------------------------------------------------------------------
// bfiq_pkg
// Shared constants and register indexes for the Bloom filter insert/query block.
// ----------------------------------------------------------------------------
package bfiq_pkg;

    localparam int unsigned DEF_MAX_FILTER_BITS = 65536;

    localparam int unsigned CFG_W  = 17;
    localparam int unsigned PRB_W  = 5;
    localparam logic [PRB_W-1:0] PROBE_CAP = 5'd16;

    // Configuration register indexes.
    localparam logic REG_FILTER_BIT_COUNT = 1'b0;
    localparam logic REG_PROBE_COUNT      = 1'b1;

    localparam logic [63:0] SEED_KEY    = 64'h0000_0000_dead_beef;
    localparam logic [63:0] SEED_REHASH = 64'h0000_0000_cafe_babe;
    localparam logic [31:0] MUL_GOLD    = 32'h9e37_79b9;
    localparam logic [31:0] MUL_FIN1    = 32'h85eb_ca6b;
    localparam logic [31:0] MUL_FIN2    = 32'hc2b2_ae35;

    // Seeded finalizer; only evaluated on constants at elaboration.
    function automatic logic [63:0] seed_hash(input logic [63:0] seed,
                                              input logic [63:0] len);
        logic [63:0] h;
        h = seed ^ (len * {32'b0, MUL_GOLD});
        h = h ^ (h >> 16);
        h = h * {32'b0, MUL_FIN1};
        h = h ^ (h >> 13);
        h = h * {32'b0, MUL_FIN2};
        h = h ^ (h >> 16);
        return h;
    endfunction

    // Starting value of the second hash, which always has length eight.
    localparam logic [63:0] H2_SEED = seed_hash(SEED_REHASH, 64'd8);

endpackage

[rtl/bfiq_ram.sv]
// ----------------------------------------------------------------------------
// bfiq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bfiq_ram #(
    parameter int unsigned WIDTH = 1,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/bloom_filter_insert_query_top.sv]
// ----------------------------------------------------------------------------
// bloom_filter_insert_query_top
// Bloom filter with double hashing, fed one key byte per item.
// ----------------------------------------------------------------------------
// After reset the block sweeps the whole bit store to zero, one bit per cycle;
// no item is accepted during that sweep, while configuration writes are taken
// at any time. One item is worked on at a time, and all hashing runs through
// one shared 32x32 multiplier. The first item of a key runs the seeded
// finalizer and then, if it carries a byte, mixes that byte in; each further
// byte item runs the byte mix. The last item of a key also runs the second
// hash, three 64-step remainder operations on a bit-serial divider and then
// the probes: an insert sets one bit per probe, and a query reads and checks
// each probe's bit in turn. With an empty filter the remainders and probes
// are skipped. A query stops probing at its first clear bit.
// Exactly one item comes out per key, on its last item, through an output
// register that holds it until it is taken.
// ----------------------------------------------------------------------------
module bloom_filter_insert_query_top #(
    parameter int unsigned MAX_FILTER_BITS = bfiq_pkg::DEF_MAX_FILTER_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [16:0] i_cfg_data,
    // Input item channel.
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_op,
    input  logic [7:0]  i_key_byte,
    input  logic        i_has_byte,
    input  logic [15:0] i_key_length,
    input  logic        i_last,
    // Result item channel.
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_present,
    output logic        o_was_query
);

    localparam int unsigned ADDR_W = $clog2(MAX_FILTER_BITS);
    localparam int unsigned CFG_W  = bfiq_pkg::CFG_W;
    localparam int unsigned PRB_W  = bfiq_pkg::PRB_W;
    localparam int unsigned REM_W  = $clog2(MAX_FILTER_BITS + 1);

    localparam logic [4:0] S_CLEAR  = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_SEED   = 5'd2;
    localparam logic [4:0] S_F1LO   = 5'd3;
    localparam logic [4:0] S_F1HI   = 5'd4;
    localparam logic [4:0] S_F2LO   = 5'd5;
    localparam logic [4:0] S_F2HI   = 5'd6;
    localparam logic [4:0] S_XOR    = 5'd7;
    localparam logic [4:0] S_GLO    = 5'd8;
    localparam logic [4:0] S_GHI    = 5'd9;
    localparam logic [4:0] S_H2INIT = 5'd10;
    localparam logic [4:0] S_H2FIN  = 5'd11;
    localparam logic [4:0] S_DIV    = 5'd12;
    localparam logic [4:0] S_PINIT  = 5'd13;
    localparam logic [4:0] S_PRB    = 5'd14;
    localparam logic [4:0] S_CHK    = 5'd15;
    localparam logic [4:0] S_RES    = 5'd16;

    // Configuration registers.
    logic [CFG_W-1:0] r_cfg_bits;
    logic [PRB_W-1:0] r_cfg_probes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_bits   <= '0;
            r_cfg_probes <= PRB_W'(2);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bfiq_pkg::REG_FILTER_BIT_COUNT: r_cfg_bits   <= i_cfg_data;
                bfiq_pkg::REG_PROBE_COUNT:      r_cfg_probes <= i_cfg_data[PRB_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective bit count and probe count, clamped to the store size and the probe cap.
    logic [REM_W-1:0] nbits;
    logic [PRB_W-1:0] nprobe;

    assign nbits  = (33'(r_cfg_bits) > 33'(MAX_FILTER_BITS)) ?
                    REM_W'(MAX_FILTER_BITS) : REM_W'(r_cfg_bits);
    assign nprobe = (r_cfg_probes > bfiq_pkg::PROBE_CAP) ?
                    bfiq_pkg::PROBE_CAP : r_cfg_probes;

    // Control and datapath registers.
    logic [4:0]        r_state, n_state;
    logic              r_in_key, n_in_key;
    logic              r_op, n_op;
    logic [7:0]        r_byte, n_byte;
    logic              r_has, n_has;
    logic [15:0]       r_len, n_len;
    logic              r_last, n_last;
    logic              r_ph, n_ph;
    logic [2:0]        r_k, n_k;
    logic [63:0]       r_h, n_h;
    logic [63:0]       r_plo, n_plo;
    logic [63:0]       r_h1, n_h1;
    logic [63:0]       r_h2, n_h2;
    logic [63:0]       r_dvd, n_dvd;
    logic [5:0]        r_dcnt, n_dcnt;
    logic [1:0]        r_dsel, n_dsel;
    logic [REM_W-1:0]  r_rem, n_rem;
    logic [REM_W-1:0]  r_pos, n_pos;
    logic [REM_W-1:0]  r_d, n_d;
    logic [REM_W-1:0]  r_w, n_w;
    logic [63:0]       r_v, n_v;
    logic [PRB_W-1:0]  r_i, n_i;
    logic              r_all, n_all;
    logic [ADDR_W-1:0] r_clr, n_clr;
    logic              r_ovalid, n_ovalid;
    logic              r_opresent, n_opresent;
    logic              r_oquery, n_oquery;

    // Shared multiplier: operand and constant chosen by the current step.
    logic [31:0] mul_a;
    logic [31:0] mul_c;
    logic [63:0] mul_p;
    logic [63:0] mul_sum;

    always_comb begin
        mul_a = r_h[31:0];
        mul_c = bfiq_pkg::MUL_GOLD;
        case (r_state)
            S_SEED:  mul_a = {16'b0, r_len};
            S_F1LO:  mul_c = bfiq_pkg::MUL_FIN1;
            S_F1HI:  begin
                mul_a = r_h[63:32];
                mul_c = bfiq_pkg::MUL_FIN1;
            end
            S_F2LO:  mul_c = bfiq_pkg::MUL_FIN2;
            S_F2HI:  begin
                mul_a = r_h[63:32];
                mul_c = bfiq_pkg::MUL_FIN2;
            end
            S_GHI:   mul_a = r_h[63:32];
            default: ;
        endcase
    end

    assign mul_p   = 64'(mul_a) * 64'(mul_c);
    assign mul_sum = r_plo + {mul_p[31:0], 32'b0};

    // One step of the restoring remainder over a 64-bit dividend.
    logic [REM_W:0]   div_t;
    logic [REM_W-1:0] rem_next;
    logic [REM_W:0]   w_inc;

    assign div_t    = {r_rem, r_dvd[63]};
    assign rem_next = (div_t >= (REM_W+1)'(nbits)) ?
                      REM_W'(div_t - (REM_W+1)'(nbits)) : REM_W'(div_t);
    assign w_inc    = (REM_W+1)'(rem_next) + 1'b1;

    // Next probe position: the remainder is carried across the 64-bit wrap
    // of h1 + i*h2 by subtracting 2^64 mod nbits whenever the sum wraps.
    logic [64:0]      v_sum;
    logic [REM_W:0]   p_t;
    logic [REM_W-1:0] p_mod;
    logic [REM_W-1:0] p_next;

    assign v_sum = {1'b0, r_v} + {1'b0, r_h2};
    assign p_t   = (REM_W+1)'(r_pos) + (REM_W+1)'(r_d);
    assign p_mod = (p_t >= (REM_W+1)'(nbits)) ?
                   REM_W'(p_t - (REM_W+1)'(nbits)) : REM_W'(p_t);

    always_comb begin
        p_next = p_mod;
        if (v_sum[64]) begin
            if (p_mod < r_w) begin
                p_next = REM_W'((REM_W+1)'(p_mod) + (REM_W+1)'(nbits)
                                - (REM_W+1)'(r_w));
            end else begin
                p_next = p_mod - r_w;
            end
        end
    end

    logic [7:0]  xor_byte;
    logic [63:0] h1_shift;
    logic        ram_rdata;
    logic        ram_we;

    assign h1_shift = r_h1 >> {r_k, 3'b000};
    assign xor_byte = r_ph ? h1_shift[7:0] : r_byte;

    always_comb begin
        n_state    = r_state;
        n_in_key   = r_in_key;
        n_op       = r_op;
        n_byte     = r_byte;
        n_has      = r_has;
        n_len      = r_len;
        n_last     = r_last;
        n_ph       = r_ph;
        n_k        = r_k;
        n_h        = r_h;
        n_plo      = r_plo;
        n_h1       = r_h1;
        n_h2       = r_h2;
        n_dvd      = r_dvd;
        n_dcnt     = r_dcnt;
        n_dsel     = r_dsel;
        n_rem      = r_rem;
        n_pos      = r_pos;
        n_d        = r_d;
        n_w        = r_w;
        n_v        = r_v;
        n_i        = r_i;
        n_all      = r_all;
        n_clr      = r_clr;
        n_ovalid   = r_ovalid;
        n_opresent = r_opresent;
        n_oquery   = r_oquery;

        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == ADDR_W'(MAX_FILTER_BITS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op     = i_op;
                    n_byte   = i_key_byte;
                    n_has    = i_has_byte;
                    n_last   = i_last;
                    n_ph     = 1'b0;
                    n_in_key = !i_last;
                    if (!r_in_key) begin
                        n_len   = i_key_length;
                        n_state = S_SEED;
                    end else if (i_has_byte) begin
                        n_state = S_XOR;
                    end else if (i_last) begin
                        n_state = S_H2INIT;
                    end
                end
            end
            S_SEED: begin
                n_h     = bfiq_pkg::SEED_KEY ^ mul_p;
                n_h     = n_h ^ (n_h >> 16);
                n_state = S_F1LO;
            end
            S_F1LO: begin
                n_plo   = mul_p;
                n_state = S_F1HI;
            end
            S_F1HI: begin
                n_h     = mul_sum ^ (mul_sum >> 13);
                n_state = S_F2LO;
            end
            S_F2LO: begin
                n_plo   = mul_p;
                n_state = S_F2HI;
            end
            S_F2HI: begin
                n_h = mul_sum ^ (mul_sum >> 16);
                if (r_has) begin
                    n_state = S_XOR;
                end else if (r_last) begin
                    n_state = S_H2INIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_XOR: begin
                n_h     = r_h ^ {56'b0, xor_byte};
                n_state = S_GLO;
            end
            S_GLO: begin
                n_plo   = mul_p;
                n_state = S_GHI;
            end
            S_GHI: begin
                n_h = mul_sum ^ (mul_sum >> 15);
                if (r_ph) begin
                    if (r_k == 3'd7) begin
                        n_state = S_H2FIN;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = S_XOR;
                    end
                end else if (r_last) begin
                    n_state = S_H2INIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_H2INIT: begin
                n_h1    = r_h;
                n_h     = bfiq_pkg::H2_SEED;
                n_ph    = 1'b1;
                n_k     = '0;
                n_state = S_XOR;
            end
            S_H2FIN: begin
                n_h2 = (r_h == 64'd0) ? 64'd1 : r_h;
                if (nbits == '0) begin
                    n_all   = 1'b0;
                    n_state = S_RES;
                end else begin
                    n_dvd   = r_h1;
                    n_dsel  = 2'd0;
                    n_dcnt  = '0;
                    n_rem   = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_rem  = rem_next;
                n_dvd  = {r_dvd[62:0], 1'b0};
                n_dcnt = r_dcnt + 1'b1;
                if (r_dcnt == 6'd63) begin
                    n_rem  = '0;
                    n_dsel = r_dsel + 1'b1;
                    case (r_dsel)
                        2'd0: begin
                            n_pos = rem_next;
                            n_dvd = r_h2;
                        end
                        2'd1: begin
                            n_d   = rem_next;
                            n_dvd = '1;
                        end
                        default: begin
                            // (2^64 - 1) mod n, plus one, folded back below n.
                            n_w     = (w_inc == (REM_W+1)'(nbits)) ?
                                      '0 : REM_W'(w_inc);
                            n_state = S_PINIT;
                        end
                    endcase
                end
            end
            S_PINIT: begin
                n_v   = r_h1;
                n_i   = '0;
                n_all = 1'b1;
                if (nprobe == '0) begin
                    n_state = S_RES;
                end else begin
                    n_state = S_PRB;
                end
            end
            S_PRB: begin
                n_pos = p_next;
                n_v   = v_sum[63:0];
                n_i   = r_i + 1'b1;
                if (r_op) begin
                    n_state = S_CHK;
                end else if (r_i + 1'b1 == nprobe) begin
                    n_state = S_RES;
                end
            end
            S_CHK: begin
                if (!ram_rdata) begin
                    n_all   = 1'b0;
                    n_state = S_RES;
                end else if (r_i == nprobe) begin
                    n_state = S_RES;
                end else begin
                    n_state = S_PRB;
                end
            end
            S_RES: begin
                if (!r_ovalid || i_out_ready) begin
                    n_ovalid   = 1'b1;
                    n_opresent = r_op & r_all;
                    n_oquery   = r_op;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_in_key <= 1'b0;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
            r_h      <= '0;
        end else begin
            r_state  <= n_state;
            r_in_key <= n_in_key;
            r_clr    <= n_clr;
            r_ovalid <= n_ovalid;
            r_h      <= n_h;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_byte     <= n_byte;
        r_has      <= n_has;
        r_len      <= n_len;
        r_last     <= n_last;
        r_ph       <= n_ph;
        r_k        <= n_k;
        r_plo      <= n_plo;
        r_h1       <= n_h1;
        r_h2       <= n_h2;
        r_dvd      <= n_dvd;
        r_dcnt     <= n_dcnt;
        r_dsel     <= n_dsel;
        r_rem      <= n_rem;
        r_pos      <= n_pos;
        r_d        <= n_d;
        r_w        <= n_w;
        r_v        <= n_v;
        r_i        <= n_i;
        r_all      <= n_all;
        r_opresent <= n_opresent;
        r_oquery   <= n_oquery;
    end

    // The bit store: cleared by the sweep, set by inserts, read by queries.
    // A probe read issued in the probe cycle is checked in the next cycle.
    assign ram_we = (r_state == S_CLEAR) || ((r_state == S_PRB) && !r_op);

    bfiq_ram #(
        .WIDTH (1),
        .DEPTH (MAX_FILTER_BITS)
    ) u_bits (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr ((r_state == S_CLEAR) ? r_clr : ADDR_W'(r_pos)),
        .i_wdata (r_state != S_CLEAR),
        .i_raddr (ADDR_W'(r_pos)),
        .o_rdata (ram_rdata)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_present   = r_opresent;
    assign o_was_query = r_oquery;

    // Every probe position must be a valid remainder of the bit count.
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PRB) |-> (r_pos < nbits))
        else $error("probe position not below the bit count");

    // The stride and the wrap correction are remainders too.
    a_stride_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PRB) |-> ((r_d < nbits) && (r_w < nbits)))
        else $error("probe stride or wrap correction out of range");

    // A new result appears only when a key finishes.
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_RES))
        else $error("result raised outside the finish step");

    // Neither an insert nor a query probes more often than the probe count allows.
    a_probe_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PRB) |-> (r_i < nprobe))
        else $error("probe index past the probe count");

endmodule

[verif/tb_bloom_filter_insert_query_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bloom_filter_insert_query_top
// Self-checking regression for the Bloom filter insert/query block.
// ----------------------------------------------------------------------------
// Keys are streamed byte by byte with random idling on both channels. A local
// copy of the filter hashes every key, applies inserts to its own bit store
// and answers queries; each result item is compared against the oldest
// expected answer. The run walks through several filter sizes and probe
// counts, including the empty filter and the oversized settings.
// ----------------------------------------------------------------------------

class bloom_scoreboard;
    bit          bits_q[65536];
    logic [63:0] key_hash;
    bit          mid_key;
    int unsigned bit_count;
    int unsigned probe_num;
    bit          answers_q[$];
    bit          kinds_q[$];
    int          errors;

    function new();
        key_hash  = '0;
        mid_key   = 1'b0;
        bit_count = 0;
        probe_num = 2;
        errors    = 0;
    endfunction

    function logic [63:0] seeded(logic [63:0] seed, logic [63:0] len);
        logic [63:0] h;
        h = seed ^ (len * 64'h9e3779b9);
        h = h ^ (h >> 16);
        h = h * 64'h85ebca6b;
        h = h ^ (h >> 13);
        h = h * 64'hc2b2ae35;
        h = h ^ (h >> 16);
        return h;
    endfunction

    function logic [63:0] mixed(logic [63:0] h, logic [7:0] b);
        h = h ^ {56'b0, b};
        h = h * 64'h9e3779b9;
        return h ^ (h >> 15);
    endfunction

    function void set_register(bit index, logic [16:0] value);
        if (index == bfiq_pkg::REG_FILTER_BIT_COUNT)
            bit_count = value;
        else
            probe_num = value[4:0];
    endfunction

    // Notes one accepted input item and, on a key's last item, queues the answer.
    function void note_item(bit op, logic [7:0] b, bit has, logic [15:0] len, bit lst);
        logic [63:0] h1;
        logic [63:0] h2;
        logic [63:0] pos;
        int unsigned nbits;
        int unsigned nprobe;
        bit all_set;
        if (!mid_key)
            key_hash = seeded(64'hdeadbeef, {48'b0, len});
        if (has)
            key_hash = mixed(key_hash, b);
        mid_key = 1'b1;
        if (!lst)
            return;
        mid_key = 1'b0;
        h1 = key_hash;
        h2 = seeded(64'hcafebabe, 64'd8);
        for (int k = 0; k < 8; k++)
            h2 = mixed(h2, h1[8*k +: 8]);
        if (h2 == 64'd0)
            h2 = 64'd1;
        nbits   = (bit_count > 65536) ? 65536 : bit_count;
        nprobe  = (probe_num > 16) ? 16 : probe_num;
        all_set = (nbits != 0);
        if (nbits != 0) begin
            for (int i = 0; i < nprobe; i++) begin
                pos = (h1 + 64'(i) * h2) % 64'(nbits);
                if (!op) begin
                    bits_q[pos] = 1'b1;
                end else if (!bits_q[pos]) begin
                    all_set = 1'b0;
                    break;
                end
            end
        end
        answers_q.push_back(op && all_set);
        kinds_q.push_back(op);
    endfunction

    function void check_result(bit present, bit was_query);
        bit exp_present;
        bit exp_query;
        if (answers_q.size() == 0) begin
            $error("unexpected result item: present=%0d was_query=%0d", present, was_query);
            errors++;
            return;
        end
        exp_present = answers_q.pop_front();
        exp_query   = kinds_q.pop_front();
        if (present !== exp_present) begin
            $error("present: expected %0d, actual %0d", exp_present, present);
            errors++;
        end
        if (was_query !== exp_query) begin
            $error("was_query: expected %0d, actual %0d", exp_query, was_query);
            errors++;
        end
    endfunction
endclass

module tb_bloom_filter_insert_query_top;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic        i_cfg_index = 0;
    logic [16:0] i_cfg_data = 0;
    logic        i_in_valid = 0;
    logic        o_in_ready;
    logic        i_op = 0;
    logic [7:0]  i_key_byte = 0;
    logic        i_has_byte = 0;
    logic [15:0] i_key_length = 0;
    logic        i_last = 0;
    logic        o_out_valid;
    logic        i_out_ready = 0;
    logic        o_present;
    logic        o_was_query;

    bloom_scoreboard filter_model = new();

    // Idling is switched off for the last part of the run.
    bit calm = 0;
    // Set while the receiver is parked, so the block backs up.
    bit hold_off = 0;

    bloom_filter_insert_query_top DUT (.*);

    always #10 i_clk = ~i_clk;

    // Result side: ready toggles in random bursts, and the checker samples
    // every accepted result at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            filter_model.check_result(o_present, o_was_query);
    end

    initial begin
        int n;
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                i_out_ready <= 0;
            end else if (calm || $urandom_range(0, 3) != 0) begin
                i_out_ready <= 1;
            end else begin
                i_out_ready <= 0;
                n = $urandom_range(0, 10);
                repeat (n) @(negedge i_clk);
            end
        end
    end

    // Offers one item and waits until the block takes it. Valid stays high
    // from one item to the next unless an idle gap is drawn.
    task automatic send_item(bit op, logic [7:0] b, bit has, logic [15:0] len, bit lst);
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        i_in_valid   <= 1;
        i_op         <= op;
        i_key_byte   <= b;
        i_has_byte   <= has;
        i_key_length <= len;
        i_last       <= lst;
        do @(posedge i_clk); while (!o_in_ready);
        filter_model.note_item(op, b, has, len, lst);
        @(negedge i_clk);
    endtask

    // Sends a whole key; with narrow set, keys are drawn from a small alphabet so that
    // queries often hit earlier inserts.
    task automatic send_key(bit op, int unsigned nbytes, bit narrow);
        logic [15:0] len;
        len = ($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'(nbytes);
        if (nbytes == 0) begin
            send_item(op, 8'($urandom), 1'b0, len, 1'b1);
            return;
        end
        for (int i = 0; i < nbytes; i++) begin
            logic [7:0] b;
            b = narrow ? 8'($urandom_range(8'h61, 8'h63)) : 8'($urandom);
            // Occasionally a byte is marked missing, or the op flips early.
            send_item((i == nbytes - 1) ? op : 1'($urandom),
                      b, ($urandom_range(0, 19) != 0), len, i == nbytes - 1);
        end
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        i_in_valid <= 0;
        while (filter_model.answers_q.size() != 0 && guard < 200000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (300) @(negedge i_clk);
    endtask

    task automatic write_reg(bit index, logic [16:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        filter_model.set_register(index, value);
        @(negedge i_clk);
        i_cfg_we <= 0;
    endtask

    initial begin
        int unsigned sent;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1;

        // Directed: empty filter first, then the extremes of each field.
        send_key(1'b0, 3, 1'b1);
        send_key(1'b1, 3, 1'b1);
        wait_drained();
        write_reg(bfiq_pkg::REG_FILTER_BIT_COUNT, 17'd64);
        write_reg(bfiq_pkg::REG_PROBE_COUNT, 17'd0);
        send_key(1'b0, 2, 1'b1);
        send_key(1'b1, 2, 1'b1);
        wait_drained();
        write_reg(bfiq_pkg::REG_PROBE_COUNT, 17'd31);
        write_reg(bfiq_pkg::REG_FILTER_BIT_COUNT, 17'h1ffff);
        send_item(1'b0, 8'h00, 1'b1, 16'hffff, 1'b0);
        send_item(1'b0, 8'hff, 1'b1, 16'h0000, 1'b1);
        send_item(1'b1, 8'h00, 1'b1, 16'hffff, 1'b0);
        send_item(1'b1, 8'hff, 1'b1, 16'h0000, 1'b1);
        send_key(1'b0, 0, 1'b0);
        send_key(1'b1, 0, 1'b0);
        send_item(1'b1, 8'h5a, 1'b0, 16'd2, 1'b0);
        send_item(1'b1, 8'ha5, 1'b1, 16'd2, 1'b1);
        send_key(1'b1, 4, 1'b0);
        wait_drained();

        // Random phases over several settings.
        sent = 0;
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(bfiq_pkg::REG_FILTER_BIT_COUNT, 17'd65536);
                    write_reg(bfiq_pkg::REG_PROBE_COUNT, 17'd16);
                end
                1: begin
                    write_reg(bfiq_pkg::REG_FILTER_BIT_COUNT, 17'd1);
                    write_reg(bfiq_pkg::REG_PROBE_COUNT, 17'd1);
                end
                2: begin
                    write_reg(bfiq_pkg::REG_FILTER_BIT_COUNT,
                              17'($urandom_range(64, 300)));
                    write_reg(bfiq_pkg::REG_PROBE_COUNT, 17'($urandom_range(1, 8)));
                end
                3: begin
                    write_reg(bfiq_pkg::REG_FILTER_BIT_COUNT, 17'd0);
                    write_reg(bfiq_pkg::REG_PROBE_COUNT, 17'd3);
                end
                4: begin
                    write_reg(bfiq_pkg::REG_FILTER_BIT_COUNT, 17'($urandom));
                    write_reg(bfiq_pkg::REG_PROBE_COUNT, 17'($urandom));
                end
                default: begin
                    write_reg(bfiq_pkg::REG_FILTER_BIT_COUNT, 17'd97);
                    write_reg(bfiq_pkg::REG_PROBE_COUNT, 17'd4);
                    calm = 1;
                end
            endcase
            for (int k = 0; k < 100; k++) begin
                int unsigned nb;
                nb = $urandom_range(0, 5);
                // Long receiver stall once, while keys keep coming.
                if (ph == 2 && k == 10)
                    hold_off = 1;
                if (ph == 2 && k == 16)
                    hold_off = 0;
                send_key(1'($urandom), nb, $urandom_range(0, 2) != 0);
                sent += (nb == 0) ? 1 : nb;
            end
            wait_drained();
        end

        // Wait out the last results.
        wait_drained();
        if (filter_model.errors == 0 && filter_model.answers_q.size() == 0)
            $display("bloom_filter_insert_query_top regression: pass");
        else
            $display("bloom_filter_insert_query_top regression: fail");
        $finish;
    end

    // Long-stall driver: parks the receiver for a counted stretch.
    initial begin
        int cnt;
        wait (hold_off);
        cnt = 0;
        while (hold_off && cnt < 3000) begin
            @(negedge i_clk);
            cnt++;
        end
        hold_off = 0;
    end

    initial begin
        #200ms;
        $display("bloom_filter_insert_query_top regression: fail");
        $finish;
    end

endmodule
